FILE: hdl/tbsp_pkg.sv
// ----------------------------------------------------------------------------
// tbsp_pkg
// Shared types and constants of the 10-bit sample packer.
// ----------------------------------------------------------------------------
`default_nettype none

package tbsp_pkg;

    localparam int DATA_W     = 16;   // data_in / data_out width
    localparam int ACC_W      = 17;   // bit accumulator width
    localparam int HELD_W     = 5;    // valid bit count width
    localparam int POS_W      = 5;    // block position width
    localparam int SAMPLE_W   = 10;   // bits per sample
    localparam int SAMPLE_LSB = 6;    // sample sits in bits 15..6
    localparam int BYTE_W     = 8;

    // Direction register codes
    localparam logic DIR_PACK   = 1'b0;
    localparam logic DIR_UNPACK = 1'b1;

    // Gearbox state carried from item to item
    typedef struct packed {
        logic [ACC_W-1:0]  acc;
        logic [HELD_W-1:0] held;
        logic [POS_W-1:0]  pos;
    } gear_state_t;

    // Up to two result beats caused by one input item
    typedef struct packed {
        logic [DATA_W-1:0] data0;
        logic              last0;
        logic [DATA_W-1:0] data1;
        logic              last1;
        logic              has0;   // at least one result
        logic              has1;   // a second result
    } result_pair_t;

endpackage

`default_nettype wire

FILE: hdl/ten_bit_sample_packer.sv
// ----------------------------------------------------------------------------
// ten_bit_sample_packer
// Bidirectional gearbox between 10-bit samples and an LSB-first byte stream.
// ----------------------------------------------------------------------------
// An input beat is registered, run through the combinational step logic,
// and its zero, one or two result beats land in a result register pair
// that drains one beat per cycle while the receiver is ready. An item with
// two results holds the output until both beats are out, so the sustained
// rate is one item per cycle only while each item gives at most one result
// and the receiver is ready; the single output channel sets that figure.
// Write the direction register only while no beats are in flight; any
// write to it starts a new block.
`default_nettype none

module ten_bit_sample_packer #(
    parameter int BLOCK_SAMPLES = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] data_in
    input  wire logic        s_axis_tlast,   // end_of_block

    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] data_out
    output logic             m_axis_tlast,   // last

    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import tbsp_pkg::*;

    logic                 direction_reg;
    logic                 cfg_write;

    logic                 in_valid_reg;
    logic [DATA_W-1:0]    in_data_reg;
    logic                 in_last_reg;

    gear_state_t          state_reg;
    gear_state_t          state_next;
    result_pair_t         step_results;

    result_pair_t         pair_reg;
    logic                 pair_valid_reg;
    logic                 pair_idx_reg;
    logic                 pair_done;
    logic                 pair_free;
    logic                 process;

    // ---- register port ----
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {31'd0, direction_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_PACK;
        end
        else if (cfg_write)
        begin
            direction_reg <= pwdata[0];
        end
    end

    // ---- handshake control ----
    assign pair_done     = m_axis_tvalid && m_axis_tready && (!pair_reg.has1 || pair_idx_reg);
    assign pair_free     = !pair_valid_reg || pair_done;
    assign process       = in_valid_reg && pair_free;
    assign s_axis_tready = !in_valid_reg || process;

    // ---- input register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // ---- step logic ----
    tbsp_step #(
        .BLOCK_SAMPLES (BLOCK_SAMPLES)
    ) u_step (
        .direction    (direction_reg),
        .state_cur    (state_reg),
        .data_in      (in_data_reg),
        .end_of_block (in_last_reg),
        .state_next   (state_next),
        .results      (step_results)
    );

    // gearbox state; a direction write starts a new block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (cfg_write)
        begin
            state_reg <= '0;
        end
        else if (process)
        begin
            state_reg <= state_next;
        end
    end

    // ---- result register pair ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid_reg <= 1'b0;
            pair_idx_reg   <= 1'b0;
        end
        else if (process)
        begin
            pair_valid_reg <= step_results.has0;
            pair_idx_reg   <= 1'b0;
        end
        else if (pair_done)
        begin
            pair_valid_reg <= 1'b0;
            pair_idx_reg   <= 1'b0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            pair_idx_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            pair_reg <= step_results;
        end
    end

    // ---- output beat select ----
    assign m_axis_tvalid = pair_valid_reg;
    assign m_axis_tdata  = pair_idx_reg ? pair_reg.data1 : pair_reg.data0;
    assign m_axis_tlast  = pair_idx_reg ? pair_reg.last1 : pair_reg.last0;

endmodule

`default_nettype wire

FILE: hdl/tbsp_step.sv
// ----------------------------------------------------------------------------
// tbsp_step
// Combinational step of the gearbox: one input item against the current
// state gives the next state and up to two result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module tbsp_step #(
    parameter int BLOCK_SAMPLES = 24
) (
    input  wire logic                         direction,
    input  wire tbsp_pkg::gear_state_t        state_cur,
    input  wire logic [tbsp_pkg::DATA_W-1:0]  data_in,
    input  wire logic                         end_of_block,
    output tbsp_pkg::gear_state_t             state_next,
    output tbsp_pkg::result_pair_t            results
);
    import tbsp_pkg::*;

    localparam logic [POS_W-1:0] BLOCK_POS = POS_W'(BLOCK_SAMPLES);

    logic [2:0]          pk_shift;
    logic [ACC_W-1:0]    pk_acc;
    logic [HELD_W-1:0]   pk_held;
    logic [ACC_W-1:0]    pk_rem;
    logic [HELD_W-1:0]   pk_rem_held;
    logic                pk_two;
    logic [POS_W-1:0]    pos_inc;
    logic                pk_end;

    logic [3:0]          up_shift;
    logic [ACC_W-1:0]    up_acc;
    logic [HELD_W-1:0]   up_held;
    logic                up_emit;
    logic [ACC_W-1:0]    up_rem;
    logic [HELD_W-1:0]   up_rem_held;
    logic                up_end_cnt;
    logic                up_frag;
    logic                up_end;

    always_comb
    begin
        pos_inc = state_cur.pos + POS_W'(1);

        // ---- pack: append sample, emit whole bytes ----
        pk_shift = state_cur.held[2:0];
        pk_acc   = state_cur.acc
                 | (ACC_W'(data_in[DATA_W-1:SAMPLE_LSB]) << pk_shift);
        pk_held  = HELD_W'(pk_shift) + HELD_W'(SAMPLE_W);
        pk_two   = (pk_held >= HELD_W'(2 * BYTE_W));
        if (pk_two)
        begin
            pk_rem      = pk_acc >> (2 * BYTE_W);
            pk_rem_held = pk_held - HELD_W'(2 * BYTE_W);
        end
        else
        begin
            pk_rem      = pk_acc >> BYTE_W;
            pk_rem_held = pk_held - HELD_W'(BYTE_W);
        end
        pk_end = end_of_block || (pos_inc >= BLOCK_POS);

        // ---- unpack: append byte, emit a sample per 10 bits ----
        up_shift = (state_cur.held > HELD_W'(9)) ? 4'd9 : state_cur.held[3:0];
        up_acc   = state_cur.acc | (ACC_W'(data_in[BYTE_W-1:0]) << up_shift);
        up_held  = HELD_W'(up_shift) + HELD_W'(BYTE_W);
        up_emit  = (up_held >= HELD_W'(SAMPLE_W));
        if (up_emit)
        begin
            up_rem      = up_acc >> SAMPLE_W;
            up_rem_held = up_held - HELD_W'(SAMPLE_W);
            up_end_cnt  = (pos_inc >= BLOCK_POS);
        end
        else
        begin
            up_rem      = up_acc;
            up_rem_held = up_held;
            up_end_cnt  = 1'b0;
        end
        up_frag = !up_end_cnt && end_of_block && (up_rem_held != '0);
        up_end  = up_end_cnt || end_of_block;

        // ---- result and state selection ----
        results    = '0;
        state_next = state_cur;
        if (direction == DIR_PACK)
        begin
            results.has0  = 1'b1;
            results.data0 = DATA_W'(pk_acc[BYTE_W-1:0]);
            if (pk_two)
            begin
                results.has1  = 1'b1;
                results.data1 = DATA_W'(pk_acc[2*BYTE_W-1:BYTE_W]);
            end
            else if (pk_end && (pk_rem_held != '0))
            begin
                // flush the partial byte, zero padded
                results.has1  = 1'b1;
                results.data1 = DATA_W'(pk_rem[BYTE_W-1:0]);
            end
            results.last0 = pk_end && !results.has1;
            results.last1 = pk_end && results.has1;
            if (pk_end)
            begin
                state_next = '0;
            end
            else
            begin
                state_next.acc  = pk_rem;
                state_next.held = pk_rem_held;
                state_next.pos  = pos_inc;
            end
        end
        else
        begin
            if (up_emit)
            begin
                results.has0  = 1'b1;
                results.data0 = {up_acc[SAMPLE_W-1:0], SAMPLE_LSB'(0)};
                if (up_frag)
                begin
                    results.has1  = 1'b1;
                    results.data1 = {up_rem[SAMPLE_W-1:0], SAMPLE_LSB'(0)};
                end
            end
            else if (up_frag)
            begin
                results.has0  = 1'b1;
                results.data0 = {up_rem[SAMPLE_W-1:0], SAMPLE_LSB'(0)};
            end
            results.last0 = up_end && results.has0 && !results.has1;
            results.last1 = up_end && results.has1;
            if (up_end)
            begin
                state_next = '0;
            end
            else
            begin
                state_next.acc  = up_rem;
                state_next.held = up_rem_held;
                state_next.pos  = up_emit ? pos_inc : state_cur.pos;
            end
        end
    end

endmodule

`default_nettype wire

FILE: bench/packer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packer_checker
// Watches the sample, byte and register traffic of the 10-bit sample packer,
// keeps its own copy of the gearbox state, predicts every result beat and
// compares each one with what the block actually sends out.
// ----------------------------------------------------------------------------

module packer_checker #(
    parameter int BLOCK_SAMPLES = 24
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] data_in
    input  logic        s_axis_tlast,   // end_of_block

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [15:0] data_out
    input  logic        m_axis_tlast,   // last

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,

    output int          error_count,
    output int          beats_pending
);

    import tbsp_pkg::*;

    localparam int DIR_REG_IDX = 0;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
    } out_beat_t;

    out_beat_t   expected_beats[$];
    logic        direction;
    gear_state_t gear;

    // Advance the gearbox by one input beat and queue the beats it produces
    task automatic step_gearbox(input logic [DATA_W-1:0] din, input logic eob);
        logic [ACC_W-1:0] acc;
        int               held;
        int               pos;
        int               n;
        logic             block_end;
        out_beat_t        beats [2];
        acc = gear.acc;
        held = gear.held;
        pos = gear.pos;
        n = 0;
        block_end = 1'b0;
        if (direction == DIR_PACK) begin
            // sample sits in bits 15..6, append above the partial byte
            acc = acc | (ACC_W'(din[15:6]) << (held % BYTE_W));
            held = (held % BYTE_W) + SAMPLE_W;
            pos = (pos + 1) % 32;
            block_end = eob || (pos >= BLOCK_SAMPLES);
            while (held >= BYTE_W && n < 2) begin
                beats[n] = '{data: {8'h00, acc[7:0]}, last: 1'b0};
                acc = acc >> BYTE_W;
                held -= BYTE_W;
                n++;
            end
            // flush the partial byte, zero padded
            if (block_end && held > 0 && n < 2) begin
                beats[n] = '{data: {8'h00, acc[7:0]}, last: 1'b0};
                n++;
            end
        end else begin
            if (held > 9)
                held = 9;
            acc = acc | (ACC_W'(din[7:0]) << held);
            held += BYTE_W;
            if (held >= SAMPLE_W) begin
                beats[n] = '{data: {acc[9:0], 6'b0}, last: 1'b0};
                n++;
                acc = acc >> SAMPLE_W;
                held -= SAMPLE_W;
                pos = (pos + 1) % 32;
                if (pos >= BLOCK_SAMPLES)
                    block_end = 1'b1;
            end
            // short block: leftover fragment becomes a final sample
            if (!block_end && eob) begin
                block_end = 1'b1;
                if (held > 0) begin
                    beats[n] = '{data: {acc[9:0], 6'b0}, last: 1'b0};
                    n++;
                end
            end
        end
        if (block_end) begin
            if (n > 0)
                beats[n-1].last = 1'b1;
            acc = '0;
            held = 0;
            pos = 0;
        end
        for (int i = 0; i < n; i++)
            expected_beats.push_back(beats[i]);
        gear.acc = acc;
        gear.held = held[HELD_W-1:0];
        gear.pos = pos[POS_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n) begin
        out_beat_t want;
        if (!rst_n) begin
            direction = DIR_PACK;
            gear = '0;
            expected_beats.delete();
            error_count = 0;
            beats_pending <= 0;
        end else begin
            // register readback
            if (psel && penable && !pwrite && pready && (paddr >> 2) == DIR_REG_IDX) begin
                if (prdata !== {31'b0, direction}) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("readback mismatch: expected %h, got %h",
                                 {31'b0, direction}, prdata);
                end
            end

            // result beat, compared before this edge's input is predicted
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_beats.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected beat: data %h last %b",
                                 m_axis_tdata, m_axis_tlast);
                end else begin
                    want = expected_beats.pop_front();
                    if (m_axis_tdata !== want.data || m_axis_tlast !== want.last) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("beat mismatch: expected %h/%b, got %h/%b",
                                     want.data, want.last, m_axis_tdata, m_axis_tlast);
                    end
                end
            end

            // direction write restarts the block
            if (psel && penable && pwrite && pready && (paddr >> 2) == DIR_REG_IDX) begin
                direction = pwdata[0];
                gear = '0;
            end

            if (s_axis_tvalid && s_axis_tready)
                step_gearbox(s_axis_tdata, s_axis_tlast);

            beats_pending <= expected_beats.size();
        end
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the 10-bit sample packer in both directions: a directed opening on
// field extremes, flushes and short blocks, then random blocks under four
// idling patterns on both streams. The checker predicts and compares.
// ----------------------------------------------------------------------------

module tb;

    import tbsp_pkg::*;

    localparam int          BLOCK_SAMPLES = 24;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int          PHASE_ITEMS   = 50;
    localparam logic [2:0]  DIR_ADDR      = 3'd0;
    localparam logic [2:0]  SPARE_ADDR    = 3'd4;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] data_in
    logic        s_axis_tlast;   // end_of_block
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] data_out
    logic        m_axis_tlast;   // last
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          error_count;
    int          beats_pending;
    int          cycle_count;
    int          sender_idle_pct;
    int          receiver_stall_pct;

    ten_bit_sample_packer #(.BLOCK_SAMPLES(BLOCK_SAMPLES)) dut (.*);

    packer_checker #(.BLOCK_SAMPLES(BLOCK_SAMPLES)) u_checker (.*);

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver backpressure
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) < receiver_stall_pct) ? 1'b0 : 1'b1;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // One input beat; valid stays high after acceptance until the next call
    task automatic send_item(input logic [15:0] din, input logic eob);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= din;
        s_axis_tlast  <= eob;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Hold input until every predicted beat is out, then let the pipe settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (beats_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic reg_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        logic dir;
        rst_n              = 1'b0;
        s_axis_tvalid      = 1'b0;
        s_axis_tdata       = '0;
        s_axis_tlast       = 1'b0;
        m_axis_tready      = 1'b1;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        cycle_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of direction is pack
        reg_access(1'b0, DIR_ADDR, '0);

        // pack: field extremes, ignored low bits, end of block on a byte boundary
        send_item(16'hffff, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'h003f, 1'b0);
        send_item(16'hffc0, 1'b1);
        // partial block, then a direction write discards it
        send_item(16'h5a80, 1'b0);
        send_item(16'ha540, 1'b0);
        drain();
        reg_access(1'b1, DIR_ADDR, {31'b0, DIR_PACK});
        send_item(16'hffc0, 1'b1);
        // a write to an unmapped register changes nothing
        drain();
        reg_access(1'b1, SPARE_ADDR, 32'hffff_ffff);
        send_item(16'h8000, 1'b1);
        drain();
        reg_access(1'b1, DIR_ADDR, 32'hffff_ffff);
        reg_access(1'b0, DIR_ADDR, '0);

        // unpack: short block that ends exactly on a sample boundary
        send_item(16'hff00, 1'b0);
        send_item(16'h00ff, 1'b0);
        send_item(16'h1234, 1'b0);
        send_item(16'habcd, 1'b0);
        send_item(16'h5555, 1'b1);
        // short block with a leftover fragment
        send_item(16'hffff, 1'b0);
        send_item(16'h0001, 1'b0);
        send_item(16'h8080, 1'b1);
        drain();

        // random blocks: each idling pattern in both directions
        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 47; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 47; end
                default: begin sender_idle_pct = 36; receiver_stall_pct = 36; end
            endcase
            dir = ((p / 4 + p) % 2 == 0) ? DIR_PACK : DIR_UNPACK;
            drain();
            reg_access(1'b1, DIR_ADDR, {31'b0, dir});
            reg_access(1'b0, DIR_ADDR, '0);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // sender holds off mid-block until the output is empty
                if (p == 5 && i == PHASE_ITEMS / 2)
                    drain();
                send_item(16'($urandom_range(0, 65535)), $urandom_range(0, 39) == 0);
            end
        end
        drain();

        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
